// ===== rtl/core/slpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// slpd_pkg
// Shared types and constants for the sync/length packet deframer.
// ============================================================================
package slpd_pkg;

    localparam logic [7:0]  SYNC_BYTE    = 8'h5a;
    localparam logic [23:0] POS_LEN0     = 24'd4;   // first length byte
    localparam logic [23:0] POS_LEN3     = 24'd7;   // last length byte
    localparam logic [23:0] HEADER_BYTES = 24'd8;   // also the type byte position

    localparam int unsigned   MAX_LEN_W       = 24;
    localparam logic [23:0]   MAX_LEN_RESET   = 24'd2622464;
    localparam int unsigned   CFG_IDX_W       = 1;
    localparam int unsigned   CFG_DATA_W      = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 1'b1;

    typedef enum logic [2:0] {
        ROLE_DISCARD = 3'd0,
        ROLE_SYNC    = 3'd1,
        ROLE_LENGTH  = 3'd2,
        ROLE_TYPE    = 3'd3,
        ROLE_PAYLOAD = 3'd4
    } t_role;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SESSION   = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_TOO_SHORT = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        t_role      role;
        logic       packet_end;
        t_status    status;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/slpd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// slpd_step
// Per-byte decode: classify one byte and compute the next frame state.
// ============================================================================
module slpd_step (
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [23:0] i_pos,
    input  wire logic [31:0] i_len,
    input  wire logic [23:0] i_max_len,
    input  wire logic        i_big_endian,
    output slpd_pkg::t_result o_result,
    output logic [23:0]      o_pos_next,
    output logic [31:0]      o_len_next
);
    import slpd_pkg::*;

    logic [31:0] w_prev;
    logic [31:0] w_len_acc;
    logic [23:0] w_pos_inc;

    assign w_prev    = (i_pos == POS_LEN0) ? 32'd0 : i_len;
    assign w_len_acc = i_big_endian ? {w_prev[23:0], i_rx_byte}
                                    : {i_rx_byte, w_prev[31:8]};
    assign w_pos_inc = i_pos + 24'd1;

    always_comb begin
        o_result.out_byte   = i_rx_byte;
        o_result.role       = ROLE_DISCARD;
        o_result.packet_end = 1'b0;
        o_result.status     = ST_OK;
        o_pos_next          = i_pos;
        o_len_next          = i_len;

        if (i_pos < POS_LEN0) begin
            // sync hunt: restart on any other byte
            if (i_rx_byte == SYNC_BYTE) begin
                o_result.role = ROLE_SYNC;
                o_pos_next    = w_pos_inc;
            end else begin
                o_pos_next    = '0;
            end
        end else if (i_pos < HEADER_BYTES) begin
            o_result.role = ROLE_LENGTH;
            o_len_next    = w_len_acc;
            o_pos_next    = w_pos_inc;
            if (i_pos == POS_LEN3) begin
                if (w_len_acc == 32'd0) begin
                    o_result.status = ST_SESSION;
                end else if (w_len_acc > {8'd0, i_max_len}) begin
                    o_result.status = ST_TOO_LARGE;
                end else if (w_len_acc <= {8'd0, HEADER_BYTES}) begin
                    o_result.status = ST_TOO_SHORT;
                end
                if (o_result.status != ST_OK) begin
                    o_pos_next = '0;
                end
            end
        end else begin
            o_result.role = (i_pos == HEADER_BYTES) ? ROLE_TYPE : ROLE_PAYLOAD;
            o_pos_next    = w_pos_inc;
            if (({8'd0, w_pos_inc} >= i_len) || (w_pos_inc == 24'd0)) begin
                o_result.packet_end = 1'b1;
                o_pos_next          = '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sync_length_packet_deframer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sync_length_packet_deframer_unit
// Splits a received byte stream into length-prefixed packets.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall) carries one received byte per
//   transaction. Output channel (o_valid / i_stall) carries one result per
//   input byte: the byte itself, its role (discarded, sync, length, type,
//   payload), a packet-end mark and a frame status reported on the last
//   length byte (ok, session reset, too large, too short).
//   A frame is four 0x5a sync bytes, a 32-bit total length (header included)
//   in the configured byte order, a type byte and the payload.
//   Throughput is one byte per cycle while the receiver does not stall:
//   the whole decode is a compare, a shift-in and a 24-bit counter
//   between the frame state registers and the result register.
//   The configuration port (i_cfg_valid / o_cfg_ready) is always ready; write
//   it only while the block is idle.
//   Reset clears the frame state to the sync hunt, empties the result
//   register and loads the default maximum length and big-endian order.
//   When the receiver stalls with a result pending, the result holds and
//   o_stall rises so the sender holds its byte; a waiting result being taken
//   frees the slot for a new byte in the same cycle.
// ============================================================================
module sync_length_packet_deframer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // byte input
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [7:0]                      i_rx_byte,
    // result output
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [7:0]                           o_out_byte,
    output logic [2:0]                           o_byte_role,
    output logic                                 o_packet_end,
    output logic [1:0]                           o_frame_status,
    // configuration
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [slpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [slpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slpd_pkg::*;

    // configuration registers
    logic [23:0] r_max_len;
    logic        r_big_endian;

    // frame state
    logic [23:0] r_pos;
    logic [31:0] r_len;
    logic [23:0] n_pos;
    logic [31:0] n_len;

    // result register
    logic        r_valid;
    t_result     r_res;
    t_result     n_res;

    logic        w_in_accept;

    assign o_cfg_ready = 1'b1;

    // Hold the sender only while a result waits on a stalled receiver.
    assign o_stall     = r_valid & i_stall;
    assign w_in_accept = i_valid & ~o_stall;

    slpd_step u_step (
        .i_rx_byte    (i_rx_byte),
        .i_pos        (r_pos),
        .i_len        (r_len),
        .i_max_len    (r_max_len),
        .i_big_endian (r_big_endian),
        .o_result     (n_res),
        .o_pos_next   (n_pos),
        .o_len_next   (n_len)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= MAX_LEN_RESET;
            r_big_endian <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_LEN:    r_max_len    <= i_cfg_data[MAX_LEN_W-1:0];
                CFG_BIG_ENDIAN: r_big_endian <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Advance frame state and load the result on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            // result taken, nothing new: drop valid
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_res.out_byte;
    assign o_byte_role    = r_res.role;
    assign o_packet_end   = r_res.packet_end;
    assign o_frame_status = r_res.status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_status_on_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status != ST_OK) |-> (r_res.role == ROLE_LENGTH))
        else $error("frame status on a non-length byte");

    a_end_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.packet_end) |->
        (r_res.role == ROLE_TYPE || r_res.role == ROLE_PAYLOAD))
        else $error("packet end outside a packet");

    a_error_rehunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (n_res.status != ST_OK || n_res.packet_end)) |=>
        (r_pos == 24'd0))
        else $error("no return to sync hunt after frame end or error");

    a_pos_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos >= HEADER_BYTES) |-> ({8'd0, r_pos} < r_len))
        else $error("byte position ran past packet length");

endmodule
`default_nettype wire
